// ----- src/ugba_pkg.sv -----
// ----------------------------------------------------------------------------
// ugba_pkg: shared types and constants of the uniform grid bin averager
// Holds the sequencer states, the divider request and response words and
// the fixed field widths.
// ----------------------------------------------------------------------------
package ugba_pkg;

    localparam int TIME_W  = 32;
    localparam int VALUE_W = 32;
    localparam int STEP_W  = 16;
    localparam int COUNT_W = 16;
    localparam int SUM_W   = 48;

    // saturation limit of the bin sample count
    localparam logic [COUNT_W-1:0] MAX_BIN_SAMPLES = 16'd65535;

    // shared divider: SUM_W-bit dividend over a STEP_W-bit divisor
    localparam int DIV_W = SUM_W;
    localparam int DEN_W = STEP_W;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DEN_W-1:0] remainder;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAN_GO,
        S_MEAN_RUN,
        S_EMIT,
        S_GRID_GO,
        S_GRID_RUN,
        S_FIN
    } t_state;

endpackage

// ----- src/ugba_sample_if.sv -----
// ----------------------------------------------------------------------------
// ugba_sample_if: input sample channel
// Valid/ready handshake carrying one timestamped sample word.
// ----------------------------------------------------------------------------
interface ugba_sample_if;
    logic                                valid;
    logic                                ready;
    logic [ugba_pkg::TIME_W-1:0]         sample_time;
    logic signed [ugba_pkg::VALUE_W-1:0] sample_value;
    logic                                last_sample;

    modport source (output valid, sample_time, sample_value, last_sample, input ready);
    modport sink   (input valid, sample_time, sample_value, last_sample, output ready);
endinterface

// ----- src/ugba_result_if.sv -----
// ----------------------------------------------------------------------------
// ugba_result_if: averaged result channel
// Valid/ready handshake carrying one grid point result word.
// ----------------------------------------------------------------------------
interface ugba_result_if;
    logic                                valid;
    logic                                ready;
    logic [ugba_pkg::TIME_W-1:0]         grid_time;
    logic signed [ugba_pkg::VALUE_W-1:0] mean_value;
    logic [ugba_pkg::COUNT_W-1:0]        bin_samples;
    logic                                series_end;

    modport source (output valid, grid_time, mean_value, bin_samples, series_end,
                    input ready);
    modport sink   (input valid, grid_time, mean_value, bin_samples, series_end,
                    output ready);
endinterface

// ----- src/ugba_divider.sv -----
// ----------------------------------------------------------------------------
// ugba_divider: shared restoring divider
// Unsigned division, one quotient bit per cycle; done pulses once when the
// quotient and remainder are final, and both hold until the next start.
// ----------------------------------------------------------------------------
module ugba_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ugba_pkg::t_div_req i_req,
    output ugba_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(ugba_pkg::DIV_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ugba_pkg::DIV_W - 1);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [ugba_pkg::DIV_W-1:0]   r_quo, n_quo;
    logic [ugba_pkg::DEN_W-1:0]   r_rem, n_rem;
    logic [ugba_pkg::DEN_W-1:0]   r_den, n_den;

    logic [ugba_pkg::DEN_W:0]     trial;
    logic [ugba_pkg::DEN_W:0]     diff;
    logic                         fits;

    always_comb begin
        trial  = {r_rem, r_quo[ugba_pkg::DIV_W-1]};
        diff   = trial - {1'b0, r_den};
        fits   = (trial >= {1'b0, r_den});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            // shift in one quotient bit, keep the partial remainder
            n_quo = {r_quo[ugba_pkg::DIV_W-2:0], fits};
            n_rem = fits ? diff[ugba_pkg::DEN_W-1:0] : trial[ugba_pkg::DEN_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// ----- src/uniform_grid_bin_averager.sv -----
// ----------------------------------------------------------------------------
// uniform_grid_bin_averager: resample timestamped samples onto a uniform grid
// Bins a time-ordered sample series around grid points spaced grid_step
// ticks apart and emits the truncated mean of every closed bin.
// ----------------------------------------------------------------------------
// A sample that falls inside the open bin's window is added at once and,
// unless it is the last of its series, the block is ready again on the next
// cycle. A sample that closes the bin takes one 48-step pass of the shared
// restoring divider for the mean of the closed bin, a hand-over to the output
// register, and a second 48-step pass that divides the distance to the sample
// by grid_step to find the next grid point. The last sample of a series adds
// one more mean pass unless it ends with an end marker. That one divider,
// one bit per cycle, paces the block. The output register lets a finished
// word wait for the sink while the next division runs; the block stalls
// only when it has a second word to hand over before the first is taken.
// A grid_step of 0 behaves as 1. A bin that reaches 65535 samples ignores
// further joining samples. Write grid_step only while the block is idle.
// ----------------------------------------------------------------------------
module uniform_grid_bin_averager (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [ugba_pkg::STEP_W-1:0]    i_cfg_wr_data,
    ugba_sample_if.sink                    i_sample,
    ugba_result_if.source                  o_result
);

    // configuration
    logic [ugba_pkg::STEP_W-1:0]   r_grid_step;
    logic [ugba_pkg::STEP_W-1:0]   step;

    // sequencer and series state
    ugba_pkg::t_state              r_state, n_state;
    logic                          r_open, n_open;
    logic                          r_beyond, n_beyond;
    logic [ugba_pkg::TIME_W-1:0]   r_gp, n_gp;
    logic [ugba_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic [ugba_pkg::COUNT_W-1:0]  r_cnt, n_cnt;

    // current sample word
    logic [ugba_pkg::TIME_W-1:0]   r_t, n_t;
    logic [ugba_pkg::VALUE_W-1:0]  r_v, n_v;
    logic                          r_last, n_last;
    logic                          r_final, n_final;
    logic                          r_marker, n_marker;
    logic                          r_neg, n_neg;

    // output register
    logic                          r_out_valid, n_out_valid;
    logic [ugba_pkg::TIME_W-1:0]   r_out_time, n_out_time;
    logic [ugba_pkg::VALUE_W-1:0]  r_out_mean, n_out_mean;
    logic [ugba_pkg::COUNT_W-1:0]  r_out_cnt, n_out_cnt;
    logic                          r_out_end, n_out_end;

    ugba_pkg::t_div_req            div_req;
    ugba_pkg::t_div_rsp            div_rsp;

    // working signals
    logic                          out_free;
    logic [ugba_pkg::TIME_W-1:0]   eff_gp;
    logic                          eff_beyond;
    logic [ugba_pkg::SUM_W-1:0]    eff_sum;
    logic [ugba_pkg::COUNT_W-1:0]  eff_cnt;
    logic [ugba_pkg::SUM_W-1:0]    in_ext;
    logic [ugba_pkg::SUM_W-1:0]    v_ext;
    logic [ugba_pkg::TIME_W+1:0]   win_lhs;
    logic [ugba_pkg::TIME_W+1:0]   win_rhs;
    logic                          joins;
    logic [ugba_pkg::SUM_W-1:0]    sum_abs;
    logic [ugba_pkg::VALUE_W-1:0]  quo_lo;
    logic [ugba_pkg::VALUE_W-1:0]  mean;
    logic [ugba_pkg::TIME_W-1:0]   rem_ext;
    logic [ugba_pkg::TIME_W-1:0]   base;
    logic                          round_up;
    logic [ugba_pkg::TIME_W:0]     next_gp;

    ugba_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // zero step acts as one
    assign step = (r_grid_step == '0) ? ugba_pkg::STEP_W'(1) : r_grid_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_step <= ugba_pkg::STEP_W'(1);
        end else if (i_cfg_wr_en) begin
            r_grid_step <= i_cfg_wr_data;
        end
    end

    always_comb begin
        // an unopened series starts its grid at this sample's time
        eff_gp     = r_open ? r_gp     : i_sample.sample_time;
        eff_beyond = r_open ? r_beyond : 1'b0;
        eff_sum    = r_open ? r_sum    : '0;
        eff_cnt    = r_open ? r_cnt    : '0;
        in_ext     = {{(ugba_pkg::SUM_W-ugba_pkg::VALUE_W){i_sample.sample_value[
                         ugba_pkg::VALUE_W-1]}}, i_sample.sample_value};
        v_ext      = {{(ugba_pkg::SUM_W-ugba_pkg::VALUE_W){r_v[ugba_pkg::VALUE_W-1]}},
                      r_v};
        // half-step window, doubled to stay exact
        win_lhs    = {1'b0, i_sample.sample_time, 1'b0};
        win_rhs    = {1'b0, eff_gp, 1'b0}
                   + {{(ugba_pkg::TIME_W+2-ugba_pkg::STEP_W){1'b0}}, step};
        joins      = eff_beyond || (win_lhs <= win_rhs);

        sum_abs    = r_sum[ugba_pkg::SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
        quo_lo     = div_rsp.quotient[ugba_pkg::VALUE_W-1:0];
        mean       = r_neg ? (~quo_lo + 1'b1) : quo_lo;

        // next grid point: t - rem, one step more when rem passes half a step
        rem_ext    = {{(ugba_pkg::TIME_W-ugba_pkg::DEN_W){1'b0}}, div_rsp.remainder};
        base       = r_t - rem_ext;
        round_up   = ({div_rsp.remainder, 1'b0} > {1'b0, step});
        next_gp    = {1'b0, base} + {{(ugba_pkg::TIME_W+1-ugba_pkg::STEP_W){1'b0}}, step};
    end

    always_comb begin
        out_free         = !r_out_valid || o_result.ready;
        n_state          = r_state;
        n_open           = r_open;
        n_beyond         = r_beyond;
        n_gp             = r_gp;
        n_sum            = r_sum;
        n_cnt            = r_cnt;
        n_t              = r_t;
        n_v              = r_v;
        n_last           = r_last;
        n_final          = r_final;
        n_marker         = r_marker;
        n_neg            = r_neg;
        n_out_valid      = r_out_valid && !o_result.ready;
        n_out_time       = r_out_time;
        n_out_mean       = r_out_mean;
        n_out_cnt        = r_out_cnt;
        n_out_end        = r_out_end;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        i_sample.ready   = (r_state == ugba_pkg::S_IDLE);

        unique case (r_state)
            ugba_pkg::S_IDLE: begin
                if (i_sample.valid) begin
                    n_t      = i_sample.sample_time;
                    n_v      = i_sample.sample_value;
                    n_last   = i_sample.last_sample;
                    n_final  = 1'b0;
                    n_marker = 1'b0;
                    if (joins) begin
                        // add to the open bin, hold a full bin as it is
                        n_open   = 1'b1;
                        n_gp     = eff_gp;
                        n_beyond = eff_beyond;
                        n_sum    = eff_sum;
                        n_cnt    = eff_cnt;
                        if (eff_cnt < ugba_pkg::MAX_BIN_SAMPLES) begin
                            n_sum = eff_sum + in_ext;
                            n_cnt = eff_cnt + 1'b1;
                        end
                        n_state = i_sample.last_sample ? ugba_pkg::S_FIN
                                                       : ugba_pkg::S_IDLE;
                    end else begin
                        // close the bin: mean first, then advance the grid
                        n_state = ugba_pkg::S_MEAN_GO;
                    end
                end
            end
            ugba_pkg::S_MEAN_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = sum_abs;
                div_req.divisor  = r_cnt;
                n_neg            = r_sum[ugba_pkg::SUM_W-1];
                n_state          = ugba_pkg::S_MEAN_RUN;
            end
            ugba_pkg::S_MEAN_RUN: begin
                if (div_rsp.done) begin
                    n_state = ugba_pkg::S_EMIT;
                end
            end
            ugba_pkg::S_EMIT: begin
                // hold until the output register is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_time  = r_gp;
                    n_out_mean  = (r_marker || r_cnt == '0) ? '0 : mean;
                    n_out_cnt   = r_marker ? '0 : r_cnt;
                    n_out_end   = r_final;
                    if (r_final) begin
                        n_open   = 1'b0;
                        n_beyond = 1'b0;
                        n_sum    = '0;
                        n_cnt    = '0;
                        n_state  = ugba_pkg::S_IDLE;
                    end else begin
                        n_state = ugba_pkg::S_GRID_GO;
                    end
                end
            end
            ugba_pkg::S_GRID_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {{(ugba_pkg::DIV_W-ugba_pkg::TIME_W){1'b0}}, r_t - r_gp};
                div_req.divisor  = step;
                n_state          = ugba_pkg::S_GRID_RUN;
            end
            ugba_pkg::S_GRID_RUN: begin
                if (div_rsp.done) begin
                    if (!round_up) begin
                        n_gp = base;
                    end else if (next_gp[ugba_pkg::TIME_W]) begin
                        // grid ran past the time range: saturate and join all
                        n_gp     = '1;
                        n_beyond = 1'b1;
                    end else begin
                        n_gp = next_gp[ugba_pkg::TIME_W-1:0];
                    end
                    // the sample opens the new bin
                    n_sum   = v_ext;
                    n_cnt   = ugba_pkg::COUNT_W'(1);
                    n_state = r_last ? ugba_pkg::S_FIN : ugba_pkg::S_IDLE;
                end
            end
            ugba_pkg::S_FIN: begin
                n_final = 1'b1;
                if (!r_beyond && (r_gp <= r_t)) begin
                    n_state = ugba_pkg::S_MEAN_GO;
                end else begin
                    // drop the final bin, send the end marker
                    n_marker = 1'b1;
                    n_state  = ugba_pkg::S_EMIT;
                end
            end
            default: begin
                n_state = ugba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ugba_pkg::S_IDLE;
            r_open      <= 1'b0;
            r_beyond    <= 1'b0;
            r_gp        <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_final     <= 1'b0;
            r_marker    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_beyond    <= n_beyond;
            r_gp        <= n_gp;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_final     <= n_final;
            r_marker    <= n_marker;
        end
        r_t        <= n_t;
        r_v        <= n_v;
        r_last     <= n_last;
        r_neg      <= n_neg;
        r_out_time <= n_out_time;
        r_out_mean <= n_out_mean;
        r_out_cnt  <= n_out_cnt;
        r_out_end  <= n_out_end;
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.grid_time   = r_out_time;
    assign o_result.mean_value  = r_out_mean;
    assign o_result.bin_samples = r_out_cnt;
    assign o_result.series_end  = r_out_end;

endmodule

// ----- sim/uniform_grid_bin_averager_test.sv -----
// ----------------------------------------------------------------------------
// uniform_grid_bin_averager_test: self-checking bench of the grid bin averager
// Drives sample words through the input channel and checks every result word
// against an in-bench model of the binning, mean and grid skip arithmetic.
// It runs directed series for the corner cases first, then random series
// under three idle patterns and a long output hold-off.
// ----------------------------------------------------------------------------
module uniform_grid_bin_averager_test;

    // cycles the block may still be busy after its last word has left:
    // one grid divider pass and some margin
    localparam int BLOCK_LATENCY = 160;
    // timeout; far above the slowest correct run with all stalls included
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_ITEMS  = 548;  // per idle phase

    typedef struct {
        logic [ugba_pkg::TIME_W-1:0]         grid_time;
        logic signed [ugba_pkg::VALUE_W-1:0] mean_value;
        logic [ugba_pkg::COUNT_W-1:0]        bin_samples;
        logic                                series_end;
    } t_bin_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [ugba_pkg::STEP_W-1:0]   i_cfg_wr_data;

    ugba_sample_if sample_ch ();
    ugba_result_if result_ch ();

    uniform_grid_bin_averager i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sample      (sample_ch),
        .o_result      (result_ch)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bin model: own copy of the register and the binning state
    // ------------------------------------------------------------------------
    logic [ugba_pkg::STEP_W-1:0]  pred_step       = 16'd1;
    logic [ugba_pkg::TIME_W-1:0]  pred_grid_point = '0;
    longint                       pred_sum        = 0;
    logic [ugba_pkg::COUNT_W-1:0] pred_count      = '0;
    bit                           pred_open       = 1'b0;
    bit                           pred_beyond     = 1'b0;

    t_bin_result expected_bins[$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_request  = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    // Add one sample; a saturated bin drops both value and count.
    function automatic void bin_accumulate(
        input logic signed [ugba_pkg::VALUE_W-1:0] value);
        if (pred_count < ugba_pkg::MAX_BIN_SAMPLES) begin
            pred_sum   = pred_sum + longint'(value);
            pred_count = pred_count + 1'b1;
        end
    endfunction

    // Truncating mean of the open bin; an empty bin gives zero.
    function automatic logic [ugba_pkg::VALUE_W-1:0] bin_mean();
        longint quotient;
        if (pred_count == 0)
            return '0;
        quotient = pred_sum / longint'(pred_count);
        return quotient[ugba_pkg::VALUE_W-1:0];
    endfunction

    function automatic void push_bin(input logic [ugba_pkg::TIME_W-1:0] gt,
                                     input logic [ugba_pkg::VALUE_W-1:0] mean,
                                     input logic [ugba_pkg::COUNT_W-1:0] cnt,
                                     input logic fin);
        t_bin_result r;
        r.grid_time   = gt;
        r.mean_value  = mean;
        r.bin_samples = cnt;
        r.series_end  = fin;
        expected_bins.insert(expected_bins.size(), r);
    endfunction

    // Work out the result words caused by one accepted sample word.
    function automatic void predict_bins(
        input logic [ugba_pkg::TIME_W-1:0] t,
        input logic signed [ugba_pkg::VALUE_W-1:0] v,
        input logic last);
        bit [63:0] step, t2, gp2, diff, k, ng;
        step = (pred_step == 0) ? 64'd1 : {48'd0, pred_step};
        if (!pred_open) begin
            pred_grid_point = t;
            pred_beyond     = 1'b0;
            pred_sum        = 0;
            pred_count      = '0;
            pred_open       = 1'b1;
        end
        // doubled times keep the half-step window exact
        t2  = {31'd0, t, 1'b0};
        gp2 = {31'd0, pred_grid_point, 1'b0};
        if (pred_beyond || t2 <= gp2 + step) begin
            bin_accumulate(v);
        end else begin
            push_bin(pred_grid_point, bin_mean(), pred_count, 1'b0);
            diff = t2 - gp2 - step;
            k    = (diff + 2 * step - 1) / (2 * step);
            ng   = {32'd0, pred_grid_point} + k * step;
            if (ng > 64'hFFFF_FFFF) begin
                pred_grid_point = '1;
                pred_beyond     = 1'b1;
            end else begin
                pred_grid_point = ng[ugba_pkg::TIME_W-1:0];
            end
            pred_sum   = 0;
            pred_count = '0;
            bin_accumulate(v);
        end
        if (last) begin
            if (!pred_beyond && pred_grid_point <= t)
                push_bin(pred_grid_point, bin_mean(), pred_count, 1'b1);
            else
                push_bin(pred_grid_point, '0, '0, 1'b1);
            pred_open   = 1'b0;
            pred_beyond = 1'b0;
            pred_sum    = 0;
            pred_count  = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Offer one sample word, idling first at random; return at the edge that
    // takes it, with valid still high so that back-to-back words stay gapless.
    task automatic send_sample(input logic [ugba_pkg::TIME_W-1:0] t,
                               input logic signed [ugba_pkg::VALUE_W-1:0] v,
                               input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_time  <= t;
        sample_ch.sample_value <= v;
        sample_ch.last_sample  <= last;
        @(posedge i_clk);
        while (!sample_ch.ready)
            @(posedge i_clk);
        predict_bins(t, v, last);
    endtask

    // Drop valid, wait for every expected word, then let the block settle.
    task automatic wait_until_idle();
        sample_ch.valid <= 1'b0;
        while (expected_bins.size() != 0)
            @(posedge i_clk);
        repeat (BLOCK_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_grid_step(input logic [ugba_pkg::STEP_W-1:0] value);
        wait_until_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pred_step = value;
    endtask

    // Result sink: check each taken word against the oldest expectation and
    // drive ready, honoring a hold-off request counted here in cycles.
    initial begin
        t_bin_result want;
        int          hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid && result_ch.ready) begin
                if (expected_bins.size() == 0) begin
                    $error("unexpected result word: grid_time %0h mean_value %0h",
                           result_ch.grid_time, result_ch.mean_value);
                    fail_count++;
                end else begin
                    want = expected_bins.pop_front();
                    if (result_ch.grid_time !== want.grid_time) begin
                        $error("grid_time: expected %0h, actual %0h",
                               want.grid_time, result_ch.grid_time);
                        fail_count++;
                    end
                    if (result_ch.mean_value !== want.mean_value) begin
                        $error("mean_value: expected %0d, actual %0d",
                               want.mean_value, result_ch.mean_value);
                        fail_count++;
                    end
                    if (result_ch.bin_samples !== want.bin_samples) begin
                        $error("bin_samples: expected %0d, actual %0d",
                               want.bin_samples, result_ch.bin_samples);
                        fail_count++;
                    end
                    if (result_ch.series_end !== want.series_end) begin
                        $error("series_end: expected %0b, actual %0b",
                               want.series_end, result_ch.series_end);
                        fail_count++;
                    end
                end
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Run on the reset step of 1, then on steps 10 and 65535: value
    // extremes, joins, closes with grid skips, negative truncation, time
    // going backwards, dropped final bins and series restarts.
    task automatic test_directed();
        // reset step of 1: open, join, close, skip
        send_sample(32'd0, 32'sh7FFF_FFFF, 1'b0);
        send_sample(32'd0, 32'sh7FFF_FFFF, 1'b0);
        send_sample(32'd1, 32'sh8000_0000, 1'b0);
        send_sample(32'd5, 32'sh8000_0000, 1'b0);
        send_sample(32'd5, -32'sd3, 1'b1);

        write_grid_step(16'd10);
        // join on the exact window edge, close, then a late sample
        // behind the grid point that ends with a dropped bin
        send_sample(32'd100, 32'sd7, 1'b0);
        send_sample(32'd105, -32'sd2, 1'b0);
        send_sample(32'd106, 32'sd0, 1'b0);
        send_sample(32'd104, -32'sd5, 1'b1);
        // one-sample series at the top of the time range
        send_sample(32'hFFFF_FFFF, -32'sd1, 1'b1);
        // skip past the last sample: dropped final bin
        send_sample(32'd50, -32'sd7, 1'b0);
        send_sample(32'd67, 32'sd9, 1'b1);
        // negative mean truncates toward zero
        send_sample(32'd200, -32'sd7, 1'b0);
        send_sample(32'd200, -32'sd8, 1'b0);
        send_sample(32'd300, 32'sd1, 1'b1);

        write_grid_step(16'hFFFF);
        // skip across the whole time range, landing exactly on the top
        send_sample(32'd0, 32'sd1, 1'b0);
        send_sample(32'hFFFF_FFFF, 32'sd2, 1'b1);
    endtask

    // A step of 0 behaves as a step of 1.
    task automatic test_zero_step();
        write_grid_step(16'd0);
        send_sample(32'd10, 32'sd4, 1'b0);
        send_sample(32'd10, 32'sd6, 1'b0);
        send_sample(32'd11, 32'sd1, 1'b0);
        send_sample(32'd14, -32'sd9, 1'b1);
    endtask

    // Skip past the top of the time range: grid saturates, later samples
    // join whatever their time, the series ends with a dropped bin; the
    // next series starts clean.
    task automatic test_grid_beyond();
        write_grid_step(16'd1000);
        send_sample(32'hFFFF_FDA7, 32'sd11, 1'b0);
        send_sample(32'hFFFF_FFFF, 32'sd12, 1'b0);
        send_sample(32'd5, 32'sd13, 1'b1);
        send_sample(32'd100, 32'sd3, 1'b1);
    endtask

    // Hold the sink off for a long stretch while each later sample closes a bin,
    // so that the output register fills and the block stalls its input.
    task automatic test_output_stall();
        int i;
        write_grid_step(16'd4);
        hold_request = 3000;
        for (i = 0; i < 40; i++)
            send_sample(32'd100 + 32'(20 * i), $urandom, (i == 39));
    endtask

    // Random series: mostly well-formed with random content, plus
    // backward steps, one-sample series and starts near the top.
    task automatic run_random_series(input int n_items);
        int                                  sent, len, i, pick;
        longint unsigned                     cur, step_l, delta;
        logic signed [ugba_pkg::VALUE_W-1:0] val;
        sent   = 0;
        step_l = (pred_step == 0) ? 1 : pred_step;
        while (sent < n_items) begin
            len  = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 14);
            pick = $urandom_range(19);
            if (pick == 0)
                cur = 0;
            else if (pick == 1)
                cur = 64'hFFFF_FFFF - $urandom_range(32'(3 * step_l));
            else
                cur = $urandom;
            for (i = 0; i < len; i++) begin
                if (i > 0) begin
                    pick = $urandom_range(99);
                    if (pick < 30) begin
                        delta = $urandom_range(32'(step_l / 2));
                    end else if (pick < 40) begin
                        delta = (step_l + $urandom_range(1)) / 2;
                    end else if (pick < 75) begin
                        delta = step_l * $urandom_range(1, 4) + $urandom_range(32'(step_l))
                                - step_l / 2;
                    end else if (pick < 85) begin
                        delta = $urandom_range(32'h0010_0000);
                    end else if (pick < 93) begin
                        // step back in time
                        delta = $urandom_range(32'(2 * step_l));
                        cur   = (cur > delta) ? cur - delta : 0;
                        delta = 0;
                    end else begin
                        delta = 0;
                    end
                    cur = cur + delta;
                    if (cur > 64'hFFFF_FFFF)
                        cur = 64'hFFFF_FFFF;
                end
                if ($urandom_range(9) == 0)
                    val = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                else
                    val = $urandom;
                send_sample(cur[ugba_pkg::TIME_W-1:0], val, (i == len - 1));
                sent++;
            end
        end
    endtask

    // One idle pattern, swept over the step extremes and two random steps.
    task automatic test_random_phase(input int src_pct, input int sink_pct);
        int s;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (s = 0; s < 4; s++) begin
            case (s)
                0:       write_grid_step(16'd1);
                1:       write_grid_step(16'hFFFF);
                2:       write_grid_step(16'($urandom_range(2, 64)));
                default: write_grid_step(16'($urandom_range(0, 65535)));
            endcase
            run_random_series(RANDOM_ITEMS / 4);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n                <= 1'b0;
        i_cfg_wr_en            <= 1'b0;
        i_cfg_wr_data          <= '0;
        sample_ch.valid        <= 1'b0;
        sample_ch.sample_time  <= '0;
        sample_ch.sample_value <= '0;
        sample_ch.last_sample  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 15;
        sink_idle_pct = 81;
        test_directed();
        test_zero_step();
        test_grid_beyond();
        test_random_phase(15, 81);
        test_random_phase(81, 15);
        test_random_phase(0, 0);
        test_output_stall();

        // drain: every expectation met, then the block's own latency
        wait_until_idle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
src/ugba_pkg.sv
src/ugba_sample_if.sv
src/ugba_result_if.sv
src/ugba_divider.sv
src/uniform_grid_bin_averager.sv
sim/uniform_grid_bin_averager_test.sv
